[src/dtp_pkg.sv]
// Shared types, constants and helper functions for the date text parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dtp_pkg;

    // Width of the saturating number accumulators
    localparam int NUMBER_WIDTH = 16;
    localparam int ACC_W        = NUMBER_WIDTH + 4;
    localparam int OUT_W        = 16;
    localparam int QUEUE_DEPTH  = 2;

    typedef logic [NUMBER_WIDTH-1:0] t_num;
    typedef logic [OUT_W-1:0]        t_out;

    localparam t_num NUM_MAX   = {NUMBER_WIDTH{1'b1}};
    localparam t_num DAY_LIMIT = NUMBER_WIDTH'(31);
    localparam t_num MON_LIMIT = NUMBER_WIDTH'(12);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [8*36-1:0] MONTH_TEXT = "JanFebMarAprMayJunJulAugSepOctNovDec";

    typedef enum logic [1:0] {
        DELIM_NONE = 2'd0,
        DELIM_AMER = 2'd1,
        DELIM_EURO = 2'd2
    } t_delim;

    // One classified character, passed from front to back
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        t_delim     delim;
        logic [3:0] month;
        logic       last;
    } t_tok;

    // Final state of one string, held for resolution
    typedef struct packed {
        logic [3:0] month;
        logic [1:0] count;
        t_num       n1;
        t_num       n2;
        t_num       n3;
        t_delim     delim;
    } t_snap;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

    // Month number 1..12 for a three-letter name in any case, 0 for none
    function automatic logic [3:0] month_of(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        for (int j = 11; j >= 0; j--) begin
            if (fold(a) == fold(MONTH_TEXT[8*(35-3*j) +: 8]) &&
                fold(b) == fold(MONTH_TEXT[8*(34-3*j) +: 8]) &&
                fold(c) == fold(MONTH_TEXT[8*(33-3*j) +: 8])) begin
                r = 4'(j + 1);
            end
        end
        return r;
    endfunction

endpackage

[src/dtp_front.sv]
// Front end: accepts characters and classifies them into tokens.
// Depends on dtp_pkg; feeds dtp_queue.
`timescale 1ns / 1ps

module dtp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output dtp_pkg::t_tok o_tok
);
    import dtp_pkg::*;

    logic [15:0] r_recent;
    logic [15:0] n_recent;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_tok.is_digit = (i_ch inside {[CH_ZERO:CH_NINE]});
        o_tok.digit    = 4'(i_ch - CH_ZERO);
        o_tok.last     = i_last;
        o_tok.month    = month_of(r_recent[15:8], r_recent[7:0], i_ch);
        case (i_ch)
            CH_SLASH, CH_DASH: o_tok.delim = DELIM_AMER;
            CH_COMMA, CH_DOT:  o_tok.delim = DELIM_EURO;
            default:           o_tok.delim = DELIM_NONE;
        endcase
    end

    // Shift in the character; clear history at end of string
    always_comb begin
        n_recent = r_recent;
        if (o_push) begin
            n_recent = i_last ? 16'd0 : {r_recent[7:0], i_ch};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= 16'd0;
        end else begin
            r_recent <= n_recent;
        end
    end

endmodule

[src/dtp_queue.sv]
// Short token queue between front and back ends.
// Depends on dtp_pkg for the token type.
`timescale 1ns / 1ps

module dtp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtp_pkg::t_tok i_tok,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_avail,
    output dtp_pkg::t_tok o_tok
);
    import dtp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_tok             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

[src/dtp_back.sv]
// Back end: number capture, month and delimiter tracking, date resolution.
// Depends on dtp_pkg; drains dtp_queue and drives the result channel.
`timescale 1ns / 1ps

module dtp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  dtp_pkg::t_tok i_tok,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [15:0]   o_year,
    output logic [15:0]   o_month,
    output logic [15:0]   o_day,
    output logic          o_valid_res
);
    import dtp_pkg::*;

    logic [3:0] r_mon, n_mon;
    logic [1:0] r_cnt, n_cnt;
    t_num       r_n1, r_n2, r_n3, n_n1, n_n2, n_n3;
    logic       r_in_dig, n_in_dig;
    t_delim     r_delim, n_delim;
    logic       r_capt, n_capt;

    t_snap      r_snap;
    logic       r_snap_v;
    logic       snap_move;
    logic       snap_free;

    logic       r_out_v;
    t_out       r_year, r_month, r_day;
    logic       r_ok;
    t_out       res_year, res_month, res_day;
    logic       res_ok;
    logic       out_free;

    t_num             acc_in;
    logic [ACC_W-1:0] acc_full;
    t_num             acc_sat;

    assign out_free  = !r_out_v || !i_stall;
    assign snap_move = r_snap_v && out_free;
    assign snap_free = !r_snap_v || snap_move;
    assign o_pop     = i_avail && (!i_tok.last || snap_free);

    assign o_valid     = r_out_v;
    assign o_year      = r_year;
    assign o_month     = r_month;
    assign o_day       = r_day;
    assign o_valid_res = r_ok;

    // Per-token state update
    always_comb begin
        n_mon    = r_mon;
        n_cnt    = r_cnt;
        n_n1     = r_n1;
        n_n2     = r_n2;
        n_n3     = r_n3;
        n_in_dig = r_in_dig;
        n_delim  = r_delim;
        n_capt   = r_capt;
        acc_in   = '0;
        acc_full = '0;
        acc_sat  = '0;
        if (o_pop) begin
            if (r_mon == 4'd0) begin
                n_mon = i_tok.month;
            end
            if (i_tok.is_digit) begin
                if (!r_in_dig) begin
                    if (r_cnt != 2'd3) begin
                        n_cnt  = r_cnt + 2'd1;
                        n_capt = 1'b1;
                    end else begin
                        n_capt = 1'b0;
                    end
                end
                case (n_cnt)
                    2'd1:    acc_in = r_n1;
                    2'd2:    acc_in = r_n2;
                    default: acc_in = r_n3;
                endcase
                acc_full = ({4'd0, acc_in} << 3) + ({4'd0, acc_in} << 1)
                           + ACC_W'(i_tok.digit);
                acc_sat  = (acc_full > ACC_W'(NUM_MAX)) ? NUM_MAX
                                                          : acc_full[NUMBER_WIDTH-1:0];
                if (n_capt) begin
                    case (n_cnt)
                        2'd1:    n_n1 = acc_sat;
                        2'd2:    n_n2 = acc_sat;
                        default: n_n3 = acc_sat;
                    endcase
                end
            end else begin
                n_capt = 1'b0;
                if (r_cnt == 2'd1 && r_delim == DELIM_NONE) begin
                    n_delim = i_tok.delim;
                end
            end
            n_in_dig = i_tok.is_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_tok.last)) begin
            r_mon    <= 4'd0;
            r_cnt    <= 2'd0;
            r_n1     <= '0;
            r_n2     <= '0;
            r_n3     <= '0;
            r_in_dig <= 1'b0;
            r_delim  <= DELIM_NONE;
            r_capt   <= 1'b0;
        end else begin
            r_mon    <= n_mon;
            r_cnt    <= n_cnt;
            r_n1     <= n_n1;
            r_n2     <= n_n2;
            r_n3     <= n_n3;
            r_in_dig <= n_in_dig;
            r_delim  <= n_delim;
            r_capt   <= n_capt;
        end
    end

    // Hold the final state of a string until the output register takes it
    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.last) begin
            r_snap.month <= n_mon;
            r_snap.count <= n_cnt;
            r_snap.n1    <= n_n1;
            r_snap.n2    <= n_n2;
            r_snap.n3    <= n_n3;
            r_snap.delim <= n_delim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v <= 1'b0;
        end else if (o_pop && i_tok.last) begin
            r_snap_v <= 1'b1;
        end else if (snap_move) begin
            r_snap_v <= 1'b0;
        end
    end

    // Resolve year, month and day from the held state
    always_comb begin
        res_year  = '0;
        res_month = '0;
        res_day   = '0;
        res_ok    = 1'b0;
        if (r_snap.month != 4'd0) begin
            if (r_snap.count >= 2'd2) begin
                res_ok    = 1'b1;
                res_month = OUT_W'(r_snap.month);
                if (r_snap.n1 > DAY_LIMIT && r_snap.n2 <= DAY_LIMIT) begin
                    res_year = OUT_W'(r_snap.n1);
                    res_day  = OUT_W'(r_snap.n2);
                end else begin
                    res_year = OUT_W'(r_snap.n2);
                    res_day  = OUT_W'(r_snap.n1);
                end
            end else if (r_snap.count == 2'd1 && r_snap.n1 > DAY_LIMIT) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n1);
                res_month = OUT_W'(r_snap.month);
                res_day   = OUT_W'(1);
            end
        end else if (r_snap.count == 2'd3) begin
            if (r_snap.n1 > DAY_LIMIT && r_snap.n3 <= DAY_LIMIT) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n1);
                res_month = OUT_W'(r_snap.n2);
                res_day   = OUT_W'(r_snap.n3);
            end else if (r_snap.n3 > DAY_LIMIT && r_snap.n1 <= DAY_LIMIT &&
                         r_snap.n1 > MON_LIMIT && r_snap.n2 <= MON_LIMIT) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n3);
                res_month = OUT_W'(r_snap.n2);
                res_day   = OUT_W'(r_snap.n1);
            end else if (r_snap.n3 > DAY_LIMIT && r_snap.n1 <= DAY_LIMIT &&
                         r_snap.n2 > MON_LIMIT && r_snap.n1 <= MON_LIMIT) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n3);
                res_month = OUT_W'(r_snap.n1);
                res_day   = OUT_W'(r_snap.n2);
            end else if (r_snap.delim == DELIM_AMER) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n3);
                res_month = OUT_W'(r_snap.n1);
                res_day   = OUT_W'(r_snap.n2);
            end else if (r_snap.delim == DELIM_EURO) begin
                res_ok    = 1'b1;
                res_year  = OUT_W'(r_snap.n3);
                res_month = OUT_W'(r_snap.n2);
                res_day   = OUT_W'(r_snap.n1);
            end
        end else if (r_snap.count != 2'd0) begin
            res_ok    = 1'b1;
            res_year  = OUT_W'(r_snap.n1);
            res_month = OUT_W'(1);
            res_day   = OUT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_year  <= res_year;
            r_month <= res_month;
            r_day   <= res_day;
            r_ok    <= res_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (snap_move) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

endmodule

[src/date_text_parser.sv]
// Date text parser: one character per cycle in unless o_stall is high, one date
// result per string out. A last character passes the queue, string snapshot and
// output register. Tokens drain one per cycle unless the snapshot is busy.
// Reset: synchronous active low; clears queue, string state and output valid.
// Depends on dtp_pkg, dtp_front, dtp_queue and dtp_back.
`timescale 1ns / 1ps

module date_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_year,
    output logic [15:0] o_month,
    output logic [15:0] o_day,
    output logic        o_valid_res
);
    import dtp_pkg::*;

    // Tokens from the classifier into the queue
    t_tok push_tok;
    logic push;
    logic q_full;

    // Tokens from the queue into the back end
    t_tok pop_tok;
    logic q_avail;
    logic pop;

    // Classify each item: digit value, delimiter class and month-name match
    // over the last three characters. Stall only when the queue is full.
    dtp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_tok   (push_tok)
    );

    // Decouple the front from the back so each side can stall on its own
    dtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_tok   (pop_tok)
    );

    // Capture numbers, resolve the date on the last token and hold the
    // result in an output register while the next string streams in
    dtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_tok       (pop_tok),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_year      (o_year),
        .o_month     (o_month),
        .o_day       (o_day),
        .o_valid_res (o_valid_res)
    );

endmodule
